FILE: sv/xcr_pkg.sv
// ----------------------------------------------------------------------------
// xcr_pkg: shared types and constants of the XMODEM-CRC receiver
// Link symbols, register indexes, the item and result records, and the
// byte-wide CRC-16/XMODEM update.
// ----------------------------------------------------------------------------
package xcr_pkg;

  // Link control symbols.
  localparam logic [7:0] SYM_SOH  = 8'h01;
  localparam logic [7:0] SYM_EOT  = 8'h04;
  localparam logic [7:0] SYM_ACK  = 8'h06;
  localparam logic [7:0] SYM_NAK  = 8'h15;
  localparam logic [7:0] SYM_CAN  = 8'h18;
  localparam logic [7:0] SYM_WAIT = 8'h43;  // ASCII 'C'

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes.
  localparam logic CFG_BASE_ADDRESS  = 1'b0;
  localparam logic CFG_SILENCE_LIMIT = 1'b1;

  // Transfer status codes.
  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_EOT      = 2'd1;
  localparam logic [1:0] ST_CAN      = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  // Queue between classifier and engine; depth is a power of two.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One classified input item.
  typedef struct packed {
    logic       is_tick;  // timer tick of silence
    logic [7:0] data;     // received byte
    logic       is_term;  // EOT or CAN
    logic       is_eot;   // EOT
    logic       is_soh;   // SOH
  } xcr_item_t;

  // One result item.
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        write_valid;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic [31:0] file_length;
    logic [1:0]  transfer_status;
  } xcr_result_t;

  // CRC-16/XMODEM update over one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/xmodem_crc_receiver.sv
// ----------------------------------------------------------------------------
// xmodem_crc_receiver: XMODEM-CRC file receiver
// Takes received serial bytes and silence ticks, sends 'C' while waiting,
// deframes packets, checks block number, complement and CRC-16/XMODEM,
// answers ACK or NAK, and writes file data to memory as it arrives.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Carries
//   -------   -------------------   ---------------------------------------
//   in_       in_valid / in_ready   op (byte or tick), received byte
//   out_      out_valid / out_ready response byte, data write, length, status
//   cfg_      cfg_we (no wait)      base address, silence limit
//
// Throughput is one item per cycle while the result side takes results,
// set by the state update with its byte-wide CRC step.
// A result reaches the output through the classifier register, the queue
// and the result register, in that order.
// Reset is synchronous and active low; it returns the receiver to waiting
// for the sender with the expected block at one and no data committed.
// Either side may stall independently: a two-entry queue and the result
// register keep the input open while a result waits, until they are full.
//
module xmodem_crc_receiver import xcr_pkg::*; #(
  parameter int BLOCK_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  // Input items.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_rx_byte,
  // Result items.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_write_valid,
  output logic [31:0] out_write_address,
  output logic [7:0]  out_write_data,
  output logic [31:0] out_file_length,
  output logic [1:0]  out_transfer_status
);

  logic [31:0] base_address_r;
  logic [7:0]  silence_limit_r;

  // Configuration must be written only while idle, which the block does not
  // enforce, so the engine reads these registers directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r  <= '0;
      silence_limit_r <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_ADDRESS:  base_address_r  <= cfg_wdata;
        CFG_SILENCE_LIMIT: silence_limit_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic        f_valid, f_ready;
  xcr_item_t   f_item;
  logic        q_valid, q_ready;
  xcr_item_t   q_item;
  xcr_result_t res;

  // The front end decodes each byte's symbol class.
  xcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_rx_byte (in_rx_byte),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  xcr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // The engine owns all protocol state and the result register.
  xcr_engine #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .base_address  (base_address_r),
    .silence_limit (silence_limit_r),
    .item_valid    (q_valid),
    .item_ready    (q_ready),
    .item          (q_item),
    .res_valid     (out_valid),
    .res_ready     (out_ready),
    .res           (res)
  );

  assign out_tx_valid        = res.tx_valid;
  assign out_tx_byte         = res.tx_byte;
  assign out_write_valid     = res.write_valid;
  assign out_write_address   = res.write_address;
  assign out_write_data      = res.write_data;
  assign out_file_length     = res.file_length;
  assign out_transfer_status = res.transfer_status;

endmodule

FILE: sv/xcr_front.sv
// ----------------------------------------------------------------------------
// xcr_front: input classifier
// Accepts input items, decodes the symbol class of each byte and holds the
// classified item in a register until the queue takes it.
// ----------------------------------------------------------------------------
module xcr_front import xcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_op,
  input  logic [7:0] in_rx_byte,
  output logic      item_valid,
  output xcr_item_t item,
  input  logic      item_ready
);

  logic      valid_r, valid_nxt;
  xcr_item_t item_r, item_nxt;
  logic      take;

  // The holding register is free when empty or when it drains this cycle.
  assign in_ready = !valid_r || item_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (take) begin
      valid_nxt       = 1'b1;
      item_nxt.is_tick = in_op;
      item_nxt.data    = in_rx_byte;
      item_nxt.is_eot  = (in_rx_byte == SYM_EOT);
      item_nxt.is_term = (in_rx_byte == SYM_EOT) || (in_rx_byte == SYM_CAN);
      item_nxt.is_soh  = (in_rx_byte == SYM_SOH);
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: sv/xcr_queue.sv
// ----------------------------------------------------------------------------
// xcr_queue: short item queue
// A small FIFO between the classifier and the engine so that each side
// stalls on its own. Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module xcr_queue import xcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  xcr_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output xcr_item_t pop_item
);

  xcr_item_t                  mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]         count_r, count_nxt;
  logic                       do_push, do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: sv/xcr_engine.sv
// ----------------------------------------------------------------------------
// xcr_engine: protocol engine
// Runs the receiver state machine on one classified item per cycle while
// the result register is free or being taken: framing, CRC, block checks,
// data writes and responses, into a result register.
// ----------------------------------------------------------------------------
module xcr_engine import xcr_pkg::*; #(
  parameter int BLOCK_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] base_address,
  input  logic [7:0]  silence_limit,
  input  logic        item_valid,
  output logic        item_ready,
  input  xcr_item_t   item,
  output logic        res_valid,
  input  logic        res_ready,
  output xcr_result_t res
);

  localparam int IDX_W = $clog2(BLOCK_BYTES + 5);
  localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(BLOCK_BYTES + 3);
  localparam logic [IDX_W-1:0] IDX_ONE    = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_TWO    = IDX_W'(2);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_RECV = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             leader_soh_r, leader_soh_nxt;
  logic [7:0]       blk_num_r, blk_num_nxt;
  logic [7:0]       blk_cpl_r, blk_cpl_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       crc_hi_r, crc_hi_nxt;
  logic [7:0]       expected_r, expected_nxt;
  logic [31:0]      committed_r, committed_nxt;
  logic [7:0]       silence_r, silence_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             res_valid_r, res_valid_nxt;
  xcr_result_t      res_r, res_nxt;

  logic             fire, recv;
  logic [IDX_W-1:0] idx;
  logic [15:0]      crc_cur;
  logic [7:0]       sil_inc;
  logic             block_ok;

  assign item_ready = !res_valid_r || res_ready;
  assign fire       = item_valid && item_ready;

  always_comb begin
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    leader_soh_nxt = leader_soh_r;
    blk_num_nxt    = blk_num_r;
    blk_cpl_nxt    = blk_cpl_r;
    crc_nxt        = crc_r;
    crc_hi_nxt     = crc_hi_r;
    expected_nxt   = expected_r;
    committed_nxt  = committed_r;
    silence_nxt    = silence_r;
    status_nxt     = status_r;
    res_valid_nxt  = res_valid_r;
    res_nxt        = res_r;

    // A byte while waiting starts a packet and is then taken as its leader.
    recv    = (phase_r == PH_RECV) || ((phase_r == PH_WAIT) && !item.is_tick);
    idx     = (phase_r == PH_WAIT) ? '0 : idx_r;
    crc_cur = (phase_r == PH_WAIT) ? '0 : crc_r;
    sil_inc = (silence_r == 8'hFF) ? silence_r : silence_r + 8'd1;
    block_ok = leader_soh_r && (blk_num_r == expected_r) &&
               (~blk_cpl_r == expected_r) && ({crc_hi_r, item.data} == crc_r);

    if (fire) begin
      res_valid_nxt       = 1'b1;
      res_nxt.tx_valid    = 1'b0;
      res_nxt.tx_byte     = '0;
      res_nxt.write_valid = 1'b0;
      res_nxt.write_address = '0;
      res_nxt.write_data  = '0;

      if (phase_r == PH_WAIT) begin
        if (item.is_tick) begin
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = SYM_WAIT;
        end else begin
          phase_nxt = PH_RECV;
        end
      end

      if (recv && item.is_tick) begin
        silence_nxt = sil_inc;
        if (sil_inc >= silence_limit) begin
          if (idx == '0) begin
            phase_nxt  = PH_DONE;
            status_nxt = ST_TIMEOUT;
          end else begin
            res_nxt.tx_valid = 1'b1;
            res_nxt.tx_byte  = SYM_NAK;
            idx_nxt     = '0;
            crc_nxt     = '0;
            silence_nxt = '0;
          end
        end
      end else if (recv) begin
        silence_nxt = '0;
        crc_nxt     = crc_cur;
        if (idx == '0) begin
          if (item.is_term) begin
            res_nxt.tx_valid = 1'b1;
            res_nxt.tx_byte  = SYM_ACK;
            phase_nxt  = PH_DONE;
            status_nxt = item.is_eot ? ST_EOT : ST_CAN;
            idx_nxt    = '0;
          end else begin
            leader_soh_nxt = item.is_soh;
            idx_nxt        = IDX_ONE;
          end
        end else if (idx == IDX_ONE) begin
          blk_num_nxt = item.data;
          idx_nxt     = IDX_TWO;
        end else if (idx == IDX_TWO) begin
          blk_cpl_nxt = item.data;
          idx_nxt     = idx + 1'b1;
        end else if (idx < IDX_CRC_HI) begin
          crc_nxt = crc16_byte(crc_cur, item.data);
          if (leader_soh_r) begin
            res_nxt.write_valid   = 1'b1;
            res_nxt.write_address = base_address + committed_r +
                                    (32'(idx) - 32'd3);
            res_nxt.write_data    = item.data;
          end
          idx_nxt = idx + 1'b1;
        end else if (idx == IDX_CRC_HI) begin
          crc_hi_nxt = item.data;
          idx_nxt    = idx + 1'b1;
        end else begin
          res_nxt.tx_valid = 1'b1;
          if (block_ok) begin
            res_nxt.tx_byte = SYM_ACK;
            committed_nxt   = committed_r + 32'(BLOCK_BYTES);
            expected_nxt    = expected_r + 8'd1;
          end else begin
            res_nxt.tx_byte = SYM_NAK;
          end
          idx_nxt = '0;
          crc_nxt = '0;
        end
      end

      res_nxt.file_length     = committed_nxt;
      res_nxt.transfer_status = status_nxt;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      idx_r        <= '0;
      leader_soh_r <= 1'b0;
      blk_num_r    <= '0;
      blk_cpl_r    <= '0;
      crc_r        <= '0;
      crc_hi_r     <= '0;
      expected_r   <= 8'd1;
      committed_r  <= '0;
      silence_r    <= '0;
      status_r     <= ST_RUNNING;
      res_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
      leader_soh_r <= leader_soh_nxt;
      blk_num_r    <= blk_num_nxt;
      blk_cpl_r    <= blk_cpl_nxt;
      crc_r        <= crc_nxt;
      crc_hi_r     <= crc_hi_nxt;
      expected_r   <= expected_nxt;
      committed_r  <= committed_nxt;
      silence_r    <= silence_nxt;
      status_r     <= status_nxt;
      res_valid_r  <= res_valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: sv/xcr_checker.sv
// ----------------------------------------------------------------------------
// xcr_checker: port checks for the XMODEM-CRC receiver
// Watches the top-level ports and flags results the protocol cannot produce.
// ----------------------------------------------------------------------------
module xcr_checker import xcr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_tx_valid,
  input logic [7:0]  out_tx_byte,
  input logic        out_write_valid,
  input logic [1:0]  out_transfer_status
);

  // The result register comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result keeps its response.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte))
    else $error("stalled result changed");

  // A data byte is never answered, and only C, ACK or NAK is ever sent.
  a_tx_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |-> !out_write_valid &&
      (out_tx_byte == SYM_WAIT || out_tx_byte == SYM_ACK ||
       out_tx_byte == SYM_NAK))
    else $error("illegal response");

  // Once the transfer has ended nothing more is written.
  a_no_write_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_transfer_status != ST_RUNNING |-> !out_write_valid)
    else $error("write after end of transfer");

  // A timeout never sends a response, then or later.
  a_timeout_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_transfer_status == ST_TIMEOUT |-> !out_tx_valid)
    else $error("response after timeout");

endmodule

bind xmodem_crc_receiver xcr_checker u_xcr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_tx_valid        (out_tx_valid),
  .out_tx_byte         (out_tx_byte),
  .out_write_valid     (out_write_valid),
  .out_transfer_status (out_transfer_status)
);

FILE: tb/sv/tb_xmodem_crc_receiver.sv
// ----------------------------------------------------------------------------
// tb_xmodem_crc_receiver: self-checking testbench of the XMODEM-CRC receiver
// Feeds serial bytes and silence ticks into the receiver and checks every
// result against a cycle-free model of the protocol. The model is kept in
// step with the stimulus. The stimulus is mostly framed packets: good,
// duplicate, misnumbered, bad complement, bad CRC, non-SOH leader and cut
// short. Noise is mixed in. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_xmodem_crc_receiver;
  import xcr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_BYTES = 128;
  localparam int FRAME_BYTES = BLOCK_BYTES + 5;  // leader, number, complement, data, CRC

  // Receiver phases as the model tracks them.
  typedef enum logic [1:0] {RX_WAIT, RX_PACKET, RX_DONE} rx_phase_t;

  // Kinds of framed packet that the stimulus builds.
  typedef enum logic [2:0] {
    PK_GOOD, PK_DUPLICATE, PK_WRONG_NUMBER, PK_WRONG_COMPLEMENT, PK_WRONG_CRC,
    PK_NOT_SOH, PK_CUT
  } pkt_kind_t;

  // How the single transfer of the run is brought to its end.
  typedef enum logic [1:0] {END_BY_EOT, END_BY_CAN, END_BY_SILENCE} end_kind_t;

  // Stall patterns of the result side.
  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_PULSED} sink_mode_t;

  // Protocol state as seen from outside the block.
  typedef struct {
    rx_phase_t   phase;
    logic [7:0]  idx;       // position within the current packet
    logic [7:0]  leader;
    logic [7:0]  blk;
    logic [7:0]  blk_n;
    logic [7:0]  crc_hi;
    logic [15:0] crc;
    logic [7:0]  next_blk;  // block number that would be accepted next
    logic [31:0] committed;
    logic [7:0]  quiet;     // silence ticks since the last byte
    logic [1:0]  status;
  } rx_state_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_write_valid;
  logic [31:0] out_write_address;
  logic [7:0]  out_write_data;
  logic [31:0] out_file_length;
  logic [1:0]  out_transfer_status;

  // Model state and its copy of the two registers.
  rx_state_t   rx;
  logic [31:0] cfg_base;
  logic [7:0]  quiet_limit;

  // Results owed by the receiver, oldest first.
  xcr_result_t pending_results[$];

  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  bit          end_allowed  = 1'b0;  // the transfer may be ended by the next item
  bit          hold_request = 1'b0;  // asks the result side for one long hold-off

  xmodem_crc_receiver #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tx_valid       (out_tx_valid),
    .out_tx_byte        (out_tx_byte),
    .out_write_valid    (out_write_valid),
    .out_write_address  (out_write_address),
    .out_write_data     (out_write_data),
    .out_file_length    (out_file_length),
    .out_transfer_status(out_transfer_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Protocol model
  // --------------------------------------------------------------------------

  // CRC-16/XMODEM over one byte, fed bit by bit from the most significant bit.
  function automatic logic [15:0] crc_xmodem_byte(logic [15:0] crc, logic [7:0] b);
    logic feedback;
    for (int k = 7; k >= 0; k--) begin
      feedback = crc[15] ^ b[k];
      crc = {crc[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
    end
    return crc;
  endfunction

  function automatic void restart_packet(inout rx_state_t s);
    s.idx   = 8'd0;
    s.crc   = 16'h0000;
    s.quiet = 8'd0;
  endfunction

  // Moves the state by one item and returns the result that it causes.
  function automatic xcr_result_t advance_receiver(inout rx_state_t s, input logic op,
                                                   input logic [7:0] b);
    xcr_result_t r;
    r = '0;
    // While waiting, a tick is answered with 'C' and a byte opens the first
    // packet; that byte is then handled as its leader in the same step.
    if (s.phase == RX_WAIT) begin
      if (op) begin
        r.tx_valid = 1'b1;
        r.tx_byte  = SYM_WAIT;
      end else begin
        s.phase = RX_PACKET;
        restart_packet(s);
      end
    end
    if (s.phase == RX_PACKET && op) begin
      if (s.quiet != 8'hFF) s.quiet++;
      if (s.quiet >= quiet_limit) begin
        // Silence with nothing received ends the transfer quietly; silence
        // inside a packet rejects what has come so far.
        if (s.idx == 8'd0) begin
          s.phase  = RX_DONE;
          s.status = ST_TIMEOUT;
        end else begin
          r.tx_valid = 1'b1;
          r.tx_byte  = SYM_NAK;
          restart_packet(s);
        end
      end
    end else if (s.phase == RX_PACKET) begin
      s.quiet = 8'd0;
      if (s.idx == 8'd0) begin
        if (b == SYM_EOT || b == SYM_CAN) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = SYM_ACK;
          s.phase    = RX_DONE;
          s.status   = (b == SYM_EOT) ? ST_EOT : ST_CAN;
        end else begin
          s.leader = b;
          s.idx    = 8'd1;
        end
      end else if (s.idx == 8'd1) begin
        s.blk = b;
        s.idx = 8'd2;
      end else if (s.idx == 8'd2) begin
        s.blk_n = b;
        s.idx   = 8'd3;
      end else if (s.idx < 8'(BLOCK_BYTES + 3)) begin
        s.crc = crc_xmodem_byte(s.crc, b);
        // Data is written as it arrives, only for SOH packets.
        if (s.leader == SYM_SOH) begin
          r.write_valid   = 1'b1;
          r.write_address = cfg_base + s.committed + 32'(s.idx) - 32'd3;
          r.write_data    = b;
        end
        s.idx++;
      end else if (s.idx == 8'(BLOCK_BYTES + 3)) begin
        s.crc_hi = b;
        s.idx++;
      end else begin
        r.tx_valid = 1'b1;
        if (s.leader == SYM_SOH && s.blk == s.next_blk &&
            (s.blk_n ^ 8'hFF) == s.next_blk && {s.crc_hi, b} == s.crc) begin
          r.tx_byte   = SYM_ACK;
          s.committed = s.committed + 32'(BLOCK_BYTES);
          s.next_blk++;
        end else begin
          r.tx_byte = SYM_NAK;
        end
        restart_packet(s);
      end
    end
    r.file_length     = s.committed;
    r.transfer_status = s.status;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one item and returns once it has been accepted. The model result
  // is queued before the offer; the block cannot answer before accepting.
  // Until the final test, an item that would end the transfer is bent into a
  // harmless byte so that the single transfer of the run stays open.
  task automatic send_item(logic op, logic [7:0] b);
    rx_state_t probe;
    int unsigned gap;
    if (!end_allowed) begin
      probe = rx;
      void'(advance_receiver(probe, op, b));
      if (probe.status != ST_RUNNING) begin
        op = 1'b0;
        if (b == SYM_EOT || b == SYM_CAN) b = b ^ 8'h80;
      end
    end
    pending_results.push_back(advance_receiver(rx, op, b));
    items_sent++;

    @(negedge clk);
    // The sender works in bursts; between bursts valid drops for a while.
    // Some bursts are long enough to give stretches with no idling at all.
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_op      <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until every owed result has been taken and the pipeline is empty.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes both registers while the block is idle. The upper bits of the
  // silence limit word are random; only the low byte counts.
  task automatic configure(logic [31:0] base, logic [7:0] limit);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE_ADDRESS;
    cfg_wdata <= base;
    @(negedge clk);
    cfg_index <= CFG_SILENCE_LIMIT;
    cfg_wdata <= {24'($urandom), limit};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_base    = base;
    quiet_limit = limit;
  endtask

  // Brings the receiver back to a packet boundary: silence where the limit
  // is short, otherwise filler bytes that complete a junk packet.
  task automatic resync();
    while (rx.phase == RX_PACKET && rx.idx != 8'd0) begin
      if (quiet_limit <= 8'd8) send_item(1'b1, 8'($urandom));
      else send_item(1'b0, 8'($urandom));
    end
  endtask

  // Builds one framed packet of the given kind and sends it, with the odd
  // silence tick between bytes that stays below the limit.
  task automatic send_packet(pkt_kind_t kind);
    logic [7:0]  frame [FRAME_BYTES];
    logic [7:0]  num;
    logic [15:0] crc;
    int unsigned fill;
    int unsigned stop_at;
    resync();
    frame[0] = SYM_SOH;
    num      = rx.next_blk;
    case (kind)
      PK_DUPLICATE:    num = rx.next_blk - 8'd1;
      PK_WRONG_NUMBER: num = rx.next_blk + 8'($urandom_range(1, 254));
      PK_NOT_SOH: begin
        do frame[0] = 8'($urandom);
        while (frame[0] == SYM_SOH || frame[0] == SYM_EOT || frame[0] == SYM_CAN);
      end
      default: ;
    endcase
    frame[1] = num;
    frame[2] = ~num;
    if (kind == PK_WRONG_COMPLEMENT) frame[2] = frame[2] ^ 8'($urandom_range(1, 255));
    // Mostly random data, now and then all zeros or all ones.
    fill = $urandom_range(0, 7);
    crc  = 16'h0000;
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      frame[3 + k] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
      crc = crc_xmodem_byte(crc, frame[3 + k]);
    end
    if (kind == PK_WRONG_CRC) crc = crc ^ 16'(1 << $urandom_range(0, 15));
    frame[FRAME_BYTES - 2] = crc[15:8];
    frame[FRAME_BYTES - 1] = crc[7:0];

    stop_at = (kind == PK_CUT) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
    for (int k = 0; k < stop_at; k++) begin
      if (k != 0 && int'(rx.quiet) + 1 < int'(quiet_limit) && $urandom_range(0, 15) == 0)
        send_item(1'b1, 8'($urandom));
      send_item(1'b0, frame[k]);
    end
    // A cut packet is left to the silence limit, which rejects it.
    if (kind == PK_CUT) begin
      while (rx.idx != 8'd0) send_item(1'b1, 8'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Before the sender starts, every tick gets a 'C', well past the silence
  // limit: waiting for the sender never times out.
  task automatic test_waiting_for_sender();
    configure(32'h0000_1000, 8'd3);
    for (int k = 0; k < 6; k++) send_item(1'b1, k[0] ? 8'hFF : 8'h00);
  endtask

  // A first packet that stops after a few data bytes. Ticks below the limit
  // are harmless and a byte clears them; then silence rejects the partial
  // packet with NAK and nothing is committed.
  task automatic test_partial_packet();
    send_item(1'b0, SYM_SOH);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'hFE);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h80);
    repeat (3) send_item(1'b1, 8'h7F);
  endtask

  // The bulk of the run: four register settings, extremes among them, each
  // with a stream of packets of every kind mixed with short bursts of noise.
  // Base 0xFFFFFFFF wraps the write address from the second data byte on,
  // and a silence limit of zero behaves as a limit of one.
  task automatic test_random_transfer();
    int unsigned start;
    int unsigned pick;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       configure(32'hFFFF_FFFF, 8'd1);
        1:       configure($urandom, 8'($urandom_range(2, 8)));
        2:       configure(32'h0000_0000, 8'd255);
        default: configure($urandom, 8'd0);
      endcase
      start = items_sent;
      while (items_sent - start < 120) begin
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
          send_packet(PK_GOOD);
        end else if (pick < 13) begin
          send_packet(pkt_kind_t'($urandom_range(PK_DUPLICATE, PK_NOT_SOH)));
        end else if (pick < 16) begin
          send_packet(PK_CUT);
        end else begin
          repeat ($urandom_range(1, 6)) send_item(1'($urandom_range(0, 1)), 8'($urandom));
        end
      end
    end
  endtask

  // The result side holds off for a long stretch while a full packet is
  // offered, so the block fills up and must stall its input.
  task automatic test_backpressure();
    hold_request = 1'b1;
    send_packet(PK_GOOD);
  endtask

  // Ends the one transfer of the run by EOT, CAN or silence at a packet
  // boundary, then checks that later items are ignored.
  task automatic test_transfer_end();
    end_kind_t how;
    resync();
    how = end_kind_t'($urandom_range(END_BY_EOT, END_BY_SILENCE));
    end_allowed = 1'b1;
    case (how)
      END_BY_EOT: send_item(1'b0, SYM_EOT);
      END_BY_CAN: send_item(1'b0, SYM_CAN);
      default: begin
        while (rx.phase != RX_DONE) send_item(1'b1, 8'($urandom));
      end
    endcase
    repeat (20) send_item(1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // The result side switches at random among its stall patterns, and
  // on request holds off for a long stretch counted here.
  initial begin : result_sink
    sink_mode_t  mode;
    int unsigned run_left;
    int unsigned hold_left;
    int unsigned cycle;
    mode      = SINK_OPEN;
    run_left  = 0;
    hold_left = 0;
    cycle     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      cycle++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 80;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = sink_mode_t'($urandom_range(SINK_OPEN, SINK_PULSED));
          run_left = $urandom_range(8, 64);
        end
        run_left--;
        case (mode)
          SINK_OPEN:   out_ready <= 1'b1;
          SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          default:     out_ready <= (cycle % 8) >= 3;
        endcase
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Every accepted result is compared with the oldest one owed.
  always @(posedge clk) begin : check_results
    xcr_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no item outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("tx_valid",        32'(want.tx_valid),        32'(out_tx_valid));
        check_field("tx_byte",         32'(want.tx_byte),         32'(out_tx_byte));
        check_field("write_valid",     32'(want.write_valid),     32'(out_write_valid));
        check_field("write_address",   want.write_address,        out_write_address);
        check_field("write_data",      32'(want.write_data),      32'(out_write_data));
        check_field("file_length",     want.file_length,          out_file_length);
        check_field("transfer_status", 32'(want.transfer_status), 32'(out_transfer_status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------

  initial begin : run_tests
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_BASE_ADDRESS;
    cfg_wdata  = 32'h0;
    in_valid   = 1'b0;
    in_op      = 1'b0;
    in_rx_byte = 8'h00;

    // Model state after reset, registers at their reset values.
    rx.phase     = RX_WAIT;
    rx.leader    = 8'd0;
    rx.blk       = 8'd0;
    rx.blk_n     = 8'd0;
    rx.crc_hi    = 8'd0;
    rx.next_blk  = 8'd1;
    rx.committed = 32'd0;
    rx.status    = ST_RUNNING;
    restart_packet(rx);
    cfg_base    = 32'd0;
    quiet_limit = 8'd4;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_waiting_for_sender();
    test_partial_packet();
    test_random_transfer();
    test_backpressure();
    test_transfer_end();
    drain();

    if (mismatches == 0) begin
      $display("xmodem_crc_receiver: match");
    end else begin
      $display("xmodem_crc_receiver: mismatch");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this.
  initial begin : watchdog
    #(10_000_000);
    $display("xmodem_crc_receiver: mismatch");
    $finish;
  end

endmodule
